// ===== rtl/assert_macros.svh =====
// assertion helper macros for the keyed impulse queue
// no dependencies; included by modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define KIQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define KIQ_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/kiq_pkg.sv =====
// shared types and constants for the keyed impulse queue
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package kiq_pkg;

   localparam int PENDING_DEPTH_DEF = 64;

   localparam int KEY_W    = 64;
   localparam int IMP_W    = 32;
   localparam int PAY_W    = 32;
   localparam int BUDGET_W = 5;
   localparam int LIM_W    = 7;

   localparam logic [BUDGET_W-1:0] BUDGET_RESET = 5'd8;
   localparam logic [BUDGET_W-1:0] BUDGET_CAP   = 5'd16;
   localparam logic [LIM_W-1:0]    LIMIT_FLOOR  = 7'd32;

   // command broadcast to every cell
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_UPDATE,
      OP_WRITE,
      OP_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [KEY_W-1:0]   key;
      logic [IMP_W-1:0]   imp;
      logic [PAY_W-1:0]   pay;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WAIT,
      ST_APPLY,
      ST_FLUSH
   } kiq_state_type;

endpackage

// ===== rtl/kiq_cell.sv =====
// one table slot: key, impulse and payload with its own update rules
// depends on kiq_pkg; instantiated in a row by the top level
`timescale 1ns / 1ps

module kiq_cell
   import kiq_pkg::*;
#(
   parameter int IDX = 0,
   parameter int IW  = 6
) (
   input  logic               clock,
   input  cell_cmd_type       cmd,
   input  logic [IW-1:0]      sel_idx,
   input  logic               occupied,
   input  logic [KEY_W-1:0]   nxt_key,
   input  logic [IMP_W-1:0]   nxt_imp,
   input  logic [PAY_W-1:0]   nxt_pay,
   output logic [KEY_W-1:0]   key,
   output logic [IMP_W-1:0]   imp,
   output logic [PAY_W-1:0]   pay,
   output logic               match
);

   logic [KEY_W-1:0] key_ff, key_in;
   logic [IMP_W-1:0] imp_ff, imp_in;
   logic [PAY_W-1:0] pay_ff, pay_in;

   // key compare against the broadcast request
   assign match = occupied && (key_ff == cmd.key);

   // slot update
   always_comb begin
      key_in = key_ff;
      imp_in = imp_ff;
      pay_in = pay_ff;
      unique case (cmd.op)
         OP_UPDATE: begin
            if (match && (cmd.imp > imp_ff)) begin
               imp_in = cmd.imp;
               pay_in = cmd.pay;
            end
         end
         OP_WRITE: begin
            if (sel_idx == IW'(IDX)) begin
               key_in = cmd.key;
               imp_in = cmd.imp;
               pay_in = cmd.pay;
            end
         end
         OP_SHIFT: begin
            key_in = nxt_key;
            imp_in = nxt_imp;
            pay_in = nxt_pay;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      imp_ff <= imp_in;
      pay_ff <= pay_in;
   end

   assign key = key_ff;
   assign imp = imp_ff;
   assign pay = pay_ff;

endmodule

// ===== rtl/kiq_min_tree.sv =====
// registered tree that finds the first slot holding the least impulse
// depends on kiq_pkg; leaf registers feed registered inner nodes up to the root
`timescale 1ns / 1ps

module kiq_min_tree
   import kiq_pkg::*;
#(
   parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
   parameter int IW            = $clog2(PENDING_DEPTH)
) (
   input  logic                     clock,
   input  logic [PENDING_DEPTH-1:0] occ,
   input  logic [IMP_W-1:0]         leaf_imp [PENDING_DEPTH],
   output logic                     min_valid,
   output logic [IMP_W-1:0]         min_imp,
   output logic [IW-1:0]            min_idx
);

   localparam int LEVELS = $clog2(PENDING_DEPTH);
   localparam int LEAVES = 1 << LEVELS;

   // heap layout: node 1 is the root, leaves start at LEAVES
   logic             vld_ff [1:2*LEAVES-1];
   logic [IMP_W-1:0] imp_ff [1:2*LEAVES-1];
   logic [IW-1:0]    idx_ff [1:2*LEAVES-1];

   // leaf registers, padding leaves stay empty
   for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
      if (i < PENDING_DEPTH) begin : g_real
         always_ff @(posedge clock) begin
            vld_ff[LEAVES+i] <= occ[i];
            imp_ff[LEAVES+i] <= leaf_imp[i];
            idx_ff[LEAVES+i] <= IW'(i);
         end
      end else begin : g_pad
         always_ff @(posedge clock) begin
            vld_ff[LEAVES+i] <= 1'b0;
            imp_ff[LEAVES+i] <= '0;
            idx_ff[LEAVES+i] <= '0;
         end
      end
   end

   // inner nodes: the left (older) side wins ties
   for (genvar k = 1; k < LEAVES; k++) begin : g_node
      logic take_right;
      assign take_right = vld_ff[2*k+1] &&
                          (!vld_ff[2*k] || (imp_ff[2*k+1] < imp_ff[2*k]));
      always_ff @(posedge clock) begin
         vld_ff[k] <= vld_ff[2*k] || vld_ff[2*k+1];
         imp_ff[k] <= take_right ? imp_ff[2*k+1] : imp_ff[2*k];
         idx_ff[k] <= take_right ? idx_ff[2*k+1] : idx_ff[2*k];
      end
   end

   assign min_valid = vld_ff[1];
   assign min_imp   = imp_ff[1];
   assign min_idx   = idx_ff[1];

endmodule

// ===== rtl/keyed_top_impulse_queue.sv =====
// top level of the keyed impulse queue: control, slot row, min tree, result register
// depends on kiq_pkg, kiq_cell, kiq_min_tree and assert_macros.svh
`timescale 1ns / 1ps
//
//  port group | direction | handshake          | contents
//  req_*      | in        | req_valid/req_stall | func, pair_key, impulse, payload
//  rsp_*      | out       | rsp_valid/rsp_stall | item_valid, impulses, payload, count, last
//  csr_*      | in        | csr_wr_en           | budget_per_frame
//
//  a queue request waits in ST_WAIT until the registered least-impulse tree has seen the
//  settled table, then is applied in ST_APPLY.
//  a flush request emits one result per cycle from the head slot while the output is not
//  stalled, the row shifting forward by one; an empty flush emits one empty last result.
//  a stalled result holds the output register; the flush waits, the table holds.
//  reset is synchronous: count clears, budget returns to 8; slot contents are not cleared.

module keyed_top_impulse_queue
   import kiq_pkg::*;
#(
   parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_func,
   input  logic [KEY_W-1:0]    req_pair_key,
   input  logic [IMP_W-1:0]    req_impulse,
   input  logic [PAY_W-1:0]    req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_item_valid,
   output logic [IMP_W-1:0]    rsp_out_impulse,
   output logic [PAY_W-1:0]    rsp_out_payload,
   output logic [BUDGET_W-1:0] rsp_flushed_count,
   output logic                rsp_last,
   input  logic                csr_wr_en,
   input  logic [BUDGET_W-1:0] csr_wr_data
);

`include "assert_macros.svh"

   localparam int IW     = $clog2(PENDING_DEPTH);
   localparam int CW     = $clog2(PENDING_DEPTH + 1);
   localparam int LEVELS = $clog2(PENDING_DEPTH);
   localparam int WCW    = $clog2(LEVELS + 2);
   localparam int LIMW   = (CW > LIM_W) ? CW : LIM_W;

   kiq_state_type st_ff, st_in;

   logic [BUDGET_W-1:0] budget_ff, budget_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [WCW-1:0]      wait_cnt_ff, wait_cnt_in;
   logic [BUDGET_W-1:0] flush_left_ff, flush_left_in;
   logic [BUDGET_W-1:0] flush_total_ff, flush_total_in;
   logic                any_match_ff;

   logic [KEY_W-1:0]    rq_key_ff;
   logic [IMP_W-1:0]    rq_imp_ff;
   logic [PAY_W-1:0]    rq_pay_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_item_ff;
   logic [IMP_W-1:0]    rsp_imp_ff;
   logic [PAY_W-1:0]    rsp_pay_ff;
   logic [BUDGET_W-1:0] rsp_cnt_ff;
   logic                rsp_last_ff;

   logic                req_accept;
   logic                slot_free;
   logic                rsp_load;
   logic                rsp_item_in;
   logic [IMP_W-1:0]    rsp_imp_in;
   logic [PAY_W-1:0]    rsp_pay_in;
   logic [BUDGET_W-1:0] rsp_cnt_in;
   logic                rsp_last_in;

   cell_cmd_type        cmd;
   cell_op_type         cmd_op;
   logic [IW-1:0]       sel_idx;

   logic [BUDGET_W-1:0] eff_budget;
   logic [LIM_W-1:0]    lim_scaled;
   logic [LIM_W-1:0]    lim_floored;
   logic [LIMW-1:0]     table_limit;
   logic                table_full;
   logic [BUDGET_W-1:0] flush_cnt;

   logic [PENDING_DEPTH-1:0] occ;
   logic [PENDING_DEPTH-1:0] match_vec;
   logic [KEY_W-1:0]    cell_key [PENDING_DEPTH];
   logic [IMP_W-1:0]    cell_imp [PENDING_DEPTH];
   logic [PAY_W-1:0]    cell_pay [PENDING_DEPTH];

   logic                min_valid;
   logic [IMP_W-1:0]    min_imp;
   logic [IW-1:0]       min_idx;

   // handshake
   assign req_stall  = (st_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   // budget, table limit and flush length
   assign eff_budget  = (budget_ff > BUDGET_CAP) ? BUDGET_CAP : budget_ff;
   assign lim_scaled  = {eff_budget, 2'b00};
   assign lim_floored = (lim_scaled < LIMIT_FLOOR) ? LIMIT_FLOOR : lim_scaled;
   assign table_limit = (LIMW'(lim_floored) > LIMW'(PENDING_DEPTH)) ?
                        LIMW'(PENDING_DEPTH) : LIMW'(lim_floored);
   assign table_full  = (LIMW'(count_ff) >= table_limit);
   assign flush_cnt   = (count_ff < CW'(eff_budget)) ? BUDGET_W'(count_ff) : eff_budget;

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (req_accept) begin
               st_in = req_func ? ST_FLUSH : ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (wait_cnt_ff == WCW'(LEVELS)) begin
               st_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            st_in = ST_IDLE;
         end
         ST_FLUSH: begin
            if (slot_free && (flush_left_ff <= 5'd1)) begin
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   // control outputs: slot command, count, result load
   always_comb begin
      cmd_op         = OP_HOLD;
      sel_idx        = '0;
      count_in       = count_ff;
      wait_cnt_in    = '0;
      flush_left_in  = flush_left_ff;
      flush_total_in = flush_total_ff;
      rsp_load       = 1'b0;
      rsp_item_in    = 1'b0;
      rsp_imp_in     = '0;
      rsp_pay_in     = '0;
      rsp_cnt_in     = '0;
      rsp_last_in    = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (req_accept && req_func) begin
               flush_left_in  = flush_cnt;
               flush_total_in = flush_cnt;
            end
         end
         ST_WAIT: begin
            wait_cnt_in = wait_cnt_ff + 1'b1;
         end
         ST_APPLY: begin
            if (any_match_ff) begin
               cmd_op = OP_UPDATE;
            end else if (table_full) begin
               if (min_valid && (rq_imp_ff > min_imp)) begin
                  cmd_op  = OP_WRITE;
                  sel_idx = min_idx;
               end
            end else begin
               cmd_op   = OP_WRITE;
               sel_idx  = IW'(count_ff);
               count_in = count_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               if (flush_left_ff == '0) begin
                  rsp_last_in = 1'b1;
               end else begin
                  cmd_op        = OP_SHIFT;
                  count_in      = count_ff - 1'b1;
                  flush_left_in = flush_left_ff - 1'b1;
                  rsp_item_in   = 1'b1;
                  rsp_imp_in    = cell_imp[0];
                  rsp_pay_in    = cell_pay[0];
                  rsp_last_in   = (flush_left_ff == 5'd1);
                  rsp_cnt_in    = (flush_left_ff == 5'd1) ? flush_total_ff : '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   assign budget_in    = csr_wr_en ? csr_wr_data : budget_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         budget_ff    <= BUDGET_RESET;
         count_ff     <= '0;
         wait_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         budget_ff    <= budget_in;
         count_ff     <= count_in;
         wait_cnt_ff  <= wait_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and flush bookkeeping
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rq_key_ff <= req_pair_key;
         rq_imp_ff <= req_impulse;
         rq_pay_ff <= req_payload;
      end
      flush_left_ff  <= flush_left_in;
      flush_total_ff <= flush_total_in;
      any_match_ff   <= |match_vec;
   end

   // result register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_item_ff <= rsp_item_in;
         rsp_imp_ff  <= rsp_imp_in;
         rsp_pay_ff  <= rsp_pay_in;
         rsp_cnt_ff  <= rsp_cnt_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_item_valid    = rsp_item_ff;
   assign rsp_out_impulse   = rsp_imp_ff;
   assign rsp_out_payload   = rsp_pay_ff;
   assign rsp_flushed_count = rsp_cnt_ff;
   assign rsp_last          = rsp_last_ff;

   // broadcast command
   always_comb begin
      cmd.op  = cmd_op;
      cmd.key = rq_key_ff;
      cmd.imp = rq_imp_ff;
      cmd.pay = rq_pay_ff;
   end

   // row of slots, each shifting toward the head on a flush
   for (genvar i = 0; i < PENDING_DEPTH; i++) begin : g_cell
      assign occ[i] = (CW'(i) < count_ff);
      if (i == PENDING_DEPTH - 1) begin : g_tail
         kiq_cell #(.IDX(i), .IW(IW)) u_cell (
            .clock    (clock),
            .cmd      (cmd),
            .sel_idx  (sel_idx),
            .occupied (occ[i]),
            .nxt_key  (cell_key[i]),
            .nxt_imp  (cell_imp[i]),
            .nxt_pay  (cell_pay[i]),
            .key      (cell_key[i]),
            .imp      (cell_imp[i]),
            .pay      (cell_pay[i]),
            .match    (match_vec[i])
         );
      end else begin : g_body
         kiq_cell #(.IDX(i), .IW(IW)) u_cell (
            .clock    (clock),
            .cmd      (cmd),
            .sel_idx  (sel_idx),
            .occupied (occ[i]),
            .nxt_key  (cell_key[i+1]),
            .nxt_imp  (cell_imp[i+1]),
            .nxt_pay  (cell_pay[i+1]),
            .key      (cell_key[i]),
            .imp      (cell_imp[i]),
            .pay      (cell_pay[i]),
            .match    (match_vec[i])
         );
      end
   end

   // least-impulse search over held slots
   kiq_min_tree #(.PENDING_DEPTH(PENDING_DEPTH), .IW(IW)) u_min_tree (
      .clock     (clock),
      .occ       (occ),
      .leaf_imp  (cell_imp),
      .min_valid (min_valid),
      .min_imp   (min_imp),
      .min_idx   (min_idx)
   );

   // checks
   `KIQ_NEVER(a_count_bound, clock, reset, count_ff > CW'(PENDING_DEPTH), "count beyond depth")
   `KIQ_ASSERT(a_append_grows, clock, reset,
      (st_ff == ST_APPLY && !any_match_ff && !table_full) |=>
      (count_ff == $past(count_ff) + 1'b1), "append did not grow count")
   `KIQ_ASSERT(a_flush_ends, clock, reset,
      (st_ff == ST_FLUSH && slot_free && flush_left_ff <= 5'd1) |=> (st_ff == ST_IDLE),
      "flush did not end after last result")
   `KIQ_NEVER(a_shift_empty, clock, reset, cmd_op == OP_SHIFT && count_ff == '0, "shift with empty table")

endmodule

// ===== verif/tb_top.sv =====
// self-checking bench for keyed_top_impulse_queue: predicts the pending impact table
// and checks every flushed result; depends on kiq_pkg and the rtl top level only
`timescale 1ns / 1ps

module tb_top;
   import kiq_pkg::*;

   localparam int          TABLE_DEPTH    = PENDING_DEPTH_DEF;
   localparam int unsigned LIMIT_SCALE    = 4;
   localparam int unsigned QUIET_CYCLES   = 24;
   localparam int unsigned HOLD_CYCLES    = 300;
   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam logic        FUNC_QUEUE     = 1'b0;
   localparam logic        FUNC_FLUSH     = 1'b1;

   typedef struct {
      bit                  drain;
      logic                func;
      logic [KEY_W-1:0]    key;
      logic [IMP_W-1:0]    impulse;
      logic [PAY_W-1:0]    payload;
   } impact_req_type;

   typedef struct {
      logic                item_valid;
      logic [IMP_W-1:0]    impulse;
      logic [PAY_W-1:0]    payload;
      logic [BUDGET_W-1:0] count;
      logic                last;
   } flush_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_func = FUNC_QUEUE;
   logic [KEY_W-1:0]    req_pair_key = '0;
   logic [IMP_W-1:0]    req_impulse = '0;
   logic [PAY_W-1:0]    req_payload = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_item_valid;
   logic [IMP_W-1:0]    rsp_out_impulse;
   logic [PAY_W-1:0]    rsp_out_payload;
   logic [BUDGET_W-1:0] rsp_flushed_count;
   logic                rsp_last;
   logic                csr_wr_en = 1'b0;
   logic [BUDGET_W-1:0] csr_wr_data = '0;

   // predicted table contents and register
   logic [KEY_W-1:0]    held_key     [TABLE_DEPTH];
   logic [IMP_W-1:0]    held_impulse [TABLE_DEPTH];
   logic [PAY_W-1:0]    held_payload [TABLE_DEPTH];
   int unsigned         held_count = 0;
   logic [BUDGET_W-1:0] budget_reg = BUDGET_RESET;

   impact_req_type      impact_reqs [$];
   flush_result_type    flush_results_due [$];
   impact_req_type      head_req;
   flush_result_type    want;

   int unsigned         sender_idle_pct = 0;
   int unsigned         rsp_stall_pct = 0;
   bit                  long_hold = 1'b0;
   int unsigned         hold_cycles = 0;
   int unsigned         quiet_count = 0;
   int unsigned         mismatch_count = 0;

   keyed_top_impulse_queue #(
      .PENDING_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_pair_key(req_pair_key),
      .req_impulse(req_impulse),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item_valid(rsp_item_valid),
      .rsp_out_impulse(rsp_out_impulse),
      .rsp_out_payload(rsp_out_payload),
      .rsp_flushed_count(rsp_flushed_count),
      .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // budget saturates at the cap
   function automatic int unsigned capped_budget();
      return (budget_reg > BUDGET_CAP) ? int'(BUDGET_CAP) : int'(budget_reg);
   endfunction

   function automatic int unsigned held_limit();
      int unsigned lim;
      lim = capped_budget() * LIMIT_SCALE;
      if (lim < LIMIT_FLOOR)
         lim = LIMIT_FLOOR;
      if (lim > TABLE_DEPTH)
         lim = TABLE_DEPTH;
      return lim;
   endfunction

   // dedup on key, else append, else replace the first least impulse
   function automatic void queue_impact(input logic [KEY_W-1:0] key,
                                        input logic [IMP_W-1:0] imp,
                                        input logic [PAY_W-1:0] pay);
      int unsigned held;
      int unsigned victim;
      int unsigned i;
      held = (held_count > TABLE_DEPTH) ? TABLE_DEPTH : held_count;
      for (i = 0; i < held; i++) begin
         if (held_key[i] == key) begin
            if (imp > held_impulse[i]) begin
               held_impulse[i] = imp;
               held_payload[i] = pay;
            end
            return;
         end
      end
      if (held >= held_limit()) begin
         if (held == 0)
            return;
         victim = 0;
         for (i = 1; i < held; i++)
            if (held_impulse[i] < held_impulse[victim])
               victim = i;
         if (imp <= held_impulse[victim])
            return;
         held_key[victim]     = key;
         held_impulse[victim] = imp;
         held_payload[victim] = pay;
         return;
      end
      held_key[held]     = key;
      held_impulse[held] = imp;
      held_payload[held] = pay;
      held_count         = held + 1;
   endfunction

   // emit the oldest entries and shift the rest forward
   function automatic void flush_oldest();
      int unsigned held;
      int unsigned emit;
      int unsigned i;
      flush_result_type res;
      held = (held_count > TABLE_DEPTH) ? TABLE_DEPTH : held_count;
      emit = capped_budget();
      if (emit > held)
         emit = held;
      if (emit == 0) begin
         res.item_valid = 1'b0;
         res.impulse    = '0;
         res.payload    = '0;
         res.count      = '0;
         res.last       = 1'b1;
         flush_results_due.push_back(res);
         return;
      end
      for (i = 0; i < emit; i++) begin
         res.item_valid = 1'b1;
         res.impulse    = held_impulse[i];
         res.payload    = held_payload[i];
         res.count      = (i + 1 == emit) ? BUDGET_W'(emit) : '0;
         res.last       = (i + 1 == emit);
         flush_results_due.push_back(res);
      end
      for (i = emit; i < held; i++) begin
         held_key[i - emit]     = held_key[i];
         held_impulse[i - emit] = held_impulse[i];
         held_payload[i - emit] = held_payload[i];
      end
      held_count = held - emit;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_func == FUNC_FLUSH)
               flush_oldest();
            else
               queue_impact(req_pair_key, req_impulse, req_payload);
         end
         if (!req_valid || !req_stall) begin
            if (impact_reqs.size() != 0 && impact_reqs[0].drain) begin
               // pause until every flushed result is back
               req_valid <= 1'b0;
               if (flush_results_due.size() == 0)
                  void'(impact_reqs.pop_front());
            end else if (impact_reqs.size() != 0 &&
                         $urandom_range(99) >= sender_idle_pct) begin
               head_req = impact_reqs.pop_front();
               req_valid    <= 1'b1;
               req_func     <= head_req.func;
               req_pair_key <= head_req.key;
               req_impulse  <= head_req.impulse;
               req_payload  <= head_req.payload;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic compare_field(input string name, input logic [31:0] exp_val,
                                input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s: expected %0h, got %0h", name, exp_val, act_val);
         mismatch_count++;
      end
   endtask

   // result monitor and receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         hold_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (flush_results_due.size() == 0) begin
               $error("unexpected result: impulse %0h payload %0h",
                      rsp_out_impulse, rsp_out_payload);
               mismatch_count++;
            end else begin
               want = flush_results_due.pop_front();
               compare_field("item_valid", want.item_valid, rsp_item_valid);
               compare_field("out_impulse", want.impulse, rsp_out_impulse);
               compare_field("out_payload", want.payload, rsp_out_payload);
               compare_field("flushed_count", want.count, rsp_flushed_count);
               compare_field("last", want.last, rsp_last);
            end
         end
         if (long_hold && hold_cycles < HOLD_CYCLES) begin
            rsp_stall   <= 1'b1;
            hold_cycles <= hold_cycles + 1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
            if (!long_hold)
               hold_cycles <= 0;
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_count <= 0;
      end else begin
         quiet_count <= quiet_count + 1;
         if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   task automatic push_req(input logic func, input logic [KEY_W-1:0] key,
                           input logic [IMP_W-1:0] imp, input logic [PAY_W-1:0] pay);
      impact_req_type r;
      r.drain   = 1'b0;
      r.func    = func;
      r.key     = key;
      r.impulse = imp;
      r.payload = pay;
      impact_reqs.push_back(r);
   endtask

   task automatic push_drain();
      impact_req_type r;
      r.drain   = 1'b1;
      r.func    = FUNC_QUEUE;
      r.key     = '0;
      r.impulse = '0;
      r.payload = '0;
      impact_reqs.push_back(r);
   endtask

   // mix of wide, tiny, float-like and extreme impulses so ties happen
   function automatic logic [IMP_W-1:0] pick_impulse();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(0, 15);
         2: return $urandom & 32'h7fff_ffff;
         default: return $urandom_range(0, 1) ? '1 : '0;
      endcase
   endfunction

   // bursts over a shared key pool ending in a flush, plus some noise
   task automatic gen_traffic(input int unsigned n, input int unsigned pool_size);
      logic [KEY_W-1:0] key_pool [$];
      int unsigned made;
      int unsigned burst;
      int unsigned k;
      for (k = 0; k < pool_size; k++)
         key_pool.push_back({$urandom, $urandom});
      made = 0;
      while (made < n) begin
         if ($urandom_range(99) < 85) begin
            burst = $urandom_range(1, 40);
            for (k = 0; k < burst && made + 1 < n; k++) begin
               push_req(FUNC_QUEUE, key_pool[$urandom_range(0, pool_size - 1)],
                        pick_impulse(), $urandom);
               made++;
            end
            push_req(FUNC_FLUSH, {$urandom, $urandom}, $urandom, $urandom);
            made++;
            if ($urandom_range(9) == 0)
               push_drain();
         end else begin
            push_req(1'($urandom_range(0, 1)), {$urandom, $urandom}, pick_impulse(),
                     $urandom);
            made++;
         end
      end
   endtask

   task automatic set_idling(input int unsigned sender_pct, input int unsigned stall_pct,
                             input bit hold);
      @(posedge clock);
      sender_idle_pct <= sender_pct;
      rsp_stall_pct   <= stall_pct;
      long_hold       <= hold;
      @(negedge clock);
   endtask

   task automatic write_budget(input logic [BUDGET_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      budget_reg  <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   // wait for the block to go idle, queue requests included
   task automatic settle();
      do
         @(negedge clock);
      while (impact_reqs.size() != 0 || req_valid || flush_results_due.size() != 0);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   initial begin
      int unsigned k;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty flush, field extremes, update strictly larger, equal, smaller
      push_req(FUNC_FLUSH, '0, '0, '0);
      push_req(FUNC_QUEUE, '0, '0, '0);
      push_req(FUNC_QUEUE, '1, '1, '1);
      push_req(FUNC_QUEUE, '0, 32'd1, 32'ha5a5_a5a5);
      push_req(FUNC_QUEUE, '0, 32'd1, 32'h5a5a_5a5a);
      push_req(FUNC_QUEUE, '0, 32'd0, 32'd1);
      push_req(FUNC_QUEUE, '1, 32'h7f80_0000, 32'd2);
      push_req(FUNC_QUEUE, 64'h8000_0000_0000_0001, 32'h3f80_0000, 32'h1234_5678);
      push_req(FUNC_FLUSH, '1, '1, '1);
      push_req(FUNC_FLUSH, '0, '0, '0);
      push_req(FUNC_QUEUE, '0, 32'd9, 32'hdead_beef);
      push_req(FUNC_FLUSH, '0, '0, '0);
      settle();

      // receiver holds off while flushes back up into the request side
      set_idling(0, 0, 1'b1);
      for (k = 0; k < 3; k++)
         push_req(FUNC_QUEUE, {$urandom, $urandom}, $urandom, $urandom);
      push_req(FUNC_FLUSH, '0, '0, '0);
      push_req(FUNC_FLUSH, '0, '0, '0);
      for (k = 0; k < 5; k++)
         push_req(FUNC_QUEUE, {$urandom, $urandom}, $urandom, $urandom);
      push_req(FUNC_FLUSH, '0, '0, '0);
      settle();

      write_budget(5'd8);
      set_idling(0, 0, 1'b0);
      gen_traffic(80, 40);
      settle();

      write_budget(5'd16);
      set_idling(61, 0, 1'b0);
      gen_traffic(70, 80);
      settle();

      // budget above the cap
      write_budget(5'd31);
      set_idling(0, 61, 1'b0);
      gen_traffic(60, 70);
      settle();

      // fill well past 32 entries at the largest limit
      write_budget(5'd16);
      set_idling(17, 17, 1'b0);
      for (k = 0; k < 4; k++)
         push_req(FUNC_FLUSH, '0, '0, '0);
      for (k = 0; k < 55; k++)
         push_req(FUNC_QUEUE, {$urandom, $urandom}, pick_impulse(), $urandom);
      settle();

      // budget lowered with the table over its new limit
      write_budget(5'd2);
      set_idling(0, 0, 1'b0);
      gen_traffic(60, 40);
      settle();

      // zero budget: every flush is empty
      write_budget(5'd0);
      set_idling(61, 0, 1'b0);
      gen_traffic(30, 20);
      settle();

      write_budget(5'd1);
      set_idling(0, 61, 1'b0);
      gen_traffic(40, 36);
      settle();

      write_budget(BUDGET_W'($urandom_range(0, 31)));
      set_idling(17, 17, 1'b0);
      gen_traffic(60, 48);
      settle();

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
